### hw/rtl/co2fd_pkg.sv
// Shared types, constants and functions for the CO2 sensor frame decoder.
// Used by co2fd_scale, co2fd_frame_ctl and the top level; depends on nothing.
`timescale 1ns / 1ps

package co2fd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [3:0] FRAME_BYTES = 4'd12;
  localparam logic [3:0] LAST_POS    = 4'd11;

  localparam logic [1:0] WORD_CO2  = 2'd0;
  localparam logic [1:0] WORD_TEMP = 2'd1;
  localparam logic [1:0] WORD_HUM  = 2'd2;
  localparam logic [1:0] WORD_STAT = 2'd3;

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] HUM_SPAN    = 15'd12500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic [14:0] HUM_OFFSET  = 15'd600;
  localparam logic [14:0] HUM_MAX     = 15'd10000;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_CRC
  } phase_t;

  typedef struct packed {
    logic [1:0] word;
    phase_t     phase;
  } slot_t;

  typedef struct packed {
    logic               fire;
    logic               status;
    logic [1:0]         bad_word;
    logic [15:0]        co2_ppm;
    logic signed [14:0] temperature_x100;
    logic [13:0]        humidity_x100;
  } frame_res_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic slot_t pos_decode(input logic [3:0] pos);
    slot_t s;
    case (pos)
      4'd0:    s = '{word: WORD_CO2,  phase: PH_HIGH};
      4'd1:    s = '{word: WORD_CO2,  phase: PH_LOW};
      4'd2:    s = '{word: WORD_CO2,  phase: PH_CRC};
      4'd3:    s = '{word: WORD_TEMP, phase: PH_HIGH};
      4'd4:    s = '{word: WORD_TEMP, phase: PH_LOW};
      4'd5:    s = '{word: WORD_TEMP, phase: PH_CRC};
      4'd6:    s = '{word: WORD_HUM,  phase: PH_HIGH};
      4'd7:    s = '{word: WORD_HUM,  phase: PH_LOW};
      4'd8:    s = '{word: WORD_HUM,  phase: PH_CRC};
      4'd9:    s = '{word: WORD_STAT, phase: PH_HIGH};
      4'd10:   s = '{word: WORD_STAT, phase: PH_LOW};
      4'd11:   s = '{word: WORD_STAT, phase: PH_CRC};
      default: s = '{word: WORD_CO2,  phase: PH_HIGH};
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/co2fd_scale.sv
// Converts a raw 16-bit sensor word to temperature and humidity in hundredths.
// Division by 65535 is a shift plus one correction step. Depends on co2fd_pkg.
`timescale 1ns / 1ps

module co2fd_scale (
  input  logic [15:0]               raw_word,
  input  logic                      is_hum,
  output logic signed [14:0]        temperature_x100,
  output logic [13:0]               humidity_x100
);
  import co2fd_pkg::*;

  logic [14:0]        span;
  logic [30:0]        prod;
  logic [14:0]        q0;
  logic [16:0]        r0;
  logic [14:0]        q;
  logic signed [15:0] t_full;
  logic [14:0]        h_diff;

  always_comb begin
    span   = is_hum ? HUM_SPAN : TEMP_SPAN;
    prod   = {15'd0, raw_word} * {16'd0, span};
    q0     = prod[30:16];
    r0     = {1'b0, prod[15:0]} + {2'd0, q0};
    q      = q0 + {14'd0, (r0 >= FULL_SCALE)};
    t_full = signed'({1'b0, q}) - TEMP_OFFSET;
    temperature_x100 = t_full[14:0];
    h_diff = q - HUM_OFFSET;
    if (q < HUM_OFFSET) begin
      humidity_x100 = 14'd0;
    end else if (h_diff > HUM_MAX) begin
      humidity_x100 = HUM_MAX[13:0];
    end else begin
      humidity_x100 = h_diff[13:0];
    end
  end

endmodule

### hw/rtl/co2fd_frame_ctl.sv
// Frame tracking: byte position, per-word CRC-8 check and word capture.
// Depends on co2fd_pkg and co2fd_scale.
`timescale 1ns / 1ps

module co2fd_frame_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  output co2fd_pkg::frame_res_t res
);
  import co2fd_pkg::*;

  logic [3:0]         pos_r, pos_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [7:0]         hi_r, hi_nxt;
  logic [15:0]        co2_r, co2_nxt;
  logic signed [14:0] temp_r, temp_nxt;
  logic [13:0]        hum_r, hum_nxt;
  logic               err_r, err_nxt;
  logic [1:0]         bad_r, bad_nxt;

  logic [3:0]         pos_eff;
  slot_t              slot;
  logic               err_base, err_upd;
  logic [1:0]         bad_base, bad_upd;
  logic               last;
  logic [15:0]        word_val;
  logic signed [14:0] temp_conv;
  logic [13:0]        hum_conv;

  co2fd_scale u_scale (
    .raw_word         (word_val),
    .is_hum           (slot.word == WORD_HUM),
    .temperature_x100 (temp_conv),
    .humidity_x100    (hum_conv)
  );

  always_comb begin
    pos_eff  = (frame_start || pos_r >= FRAME_BYTES) ? 4'd0 : pos_r;
    slot     = pos_decode(pos_eff);
    err_base = frame_start ? 1'b0 : err_r;
    bad_base = frame_start ? 2'd0 : bad_r;
    word_val = {hi_r, data_byte};
    last     = (pos_eff == LAST_POS);

    crc_nxt  = crc_r;
    hi_nxt   = hi_r;
    co2_nxt  = co2_r;
    temp_nxt = temp_r;
    hum_nxt  = hum_r;
    err_upd  = err_base;
    bad_upd  = bad_base;

    case (slot.phase)
      PH_HIGH: begin
        crc_nxt = crc_byte(CRC_INIT, data_byte);
        hi_nxt  = data_byte;
      end
      PH_LOW: begin
        crc_nxt = crc_byte(crc_r, data_byte);
        case (slot.word)
          WORD_CO2:  co2_nxt  = word_val;
          WORD_TEMP: temp_nxt = temp_conv;
          WORD_HUM:  hum_nxt  = hum_conv;
          default:   co2_nxt  = co2_r;
        endcase
      end
      PH_CRC: begin
        if (crc_r != data_byte && !err_base) begin
          err_upd = 1'b1;
          bad_upd = slot.word;
        end
        crc_nxt = CRC_INIT;
      end
      default: crc_nxt = CRC_INIT;
    endcase

    pos_nxt = last ? 4'd0 : pos_eff + 4'd1;
    err_nxt = last ? 1'b0 : err_upd;
    bad_nxt = last ? 2'd0 : bad_upd;

    res.fire             = last;
    res.status           = err_upd;
    res.bad_word         = err_upd ? bad_upd : 2'd0;
    res.co2_ppm          = err_upd ? 16'd0 : co2_nxt;
    res.temperature_x100 = err_upd ? 15'sd0 : temp_nxt;
    res.humidity_x100    = err_upd ? 14'd0 : hum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 4'd0;
      crc_r  <= CRC_INIT;
      hi_r   <= 8'd0;
      co2_r  <= 16'd0;
      temp_r <= 15'sd0;
      hum_r  <= 14'd0;
      err_r  <= 1'b0;
      bad_r  <= 2'd0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      hi_r   <= hi_nxt;
      co2_r  <= co2_nxt;
      temp_r <= temp_nxt;
      hum_r  <= hum_nxt;
      err_r  <= err_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

### hw/rtl/co2_sensor_frame_decoder_unit.sv
// CO2 sensor frame decoder, top level: input register, frame logic, result register.
// Throughput: one byte per cycle, unless an untaken result stalls the input at a frame end.
// A result follows the twelfth byte of each frame: that byte waits in the input register
// until the output side is free, then the result register loads and out_tvalid rises.
// Reset (rst_n, synchronous, active low) empties both registers and restarts the frame.
// Depends on co2fd_pkg, co2fd_frame_ctl and co2fd_scale.
`timescale 1ns / 1ps

module co2_sensor_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] bad_word, [17:2] co2_ppm,
                                  // [32:18] temperature_x100, [46:33] humidity_x100, [47] 0
  output logic        out_tuser   // [0] result_status
);
  import co2fd_pkg::*;

  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       start_r;
  logic       advance;
  frame_res_t res;
  logic       out_valid_r;
  logic       status_r;
  logic [46:0] payload_r;

  co2fd_frame_ctl u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .data_byte   (byte_r),
    .frame_start (start_r),
    .res         (res)
  );

  assign advance   = in_valid_r && (!res.fire || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.fire) begin
      status_r  <= res.status;
      payload_r <= {res.humidity_x100, res.temperature_x100, res.co2_ppm, res.bad_word};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, payload_r};
  assign out_tuser  = status_r;

endmodule

### hw/rtl/co2fd_checker.sv
// Port-level checks for the CO2 sensor frame decoder and the bind that attaches them.
// Depends on co2_sensor_frame_decoder_unit.
`timescale 1ns / 1ps

module co2fd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result request changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:2] == 46'd0)
    else $error("error result carries measurement data");

  a_ok_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[1:0] == 2'd0 && out_tdata[47] == 1'b0)
    else $error("valid result names a bad word");

  a_hum_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[46:33] <= 14'd10000)
    else $error("humidity above clamp");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind co2_sensor_frame_decoder_unit co2fd_checker u_co2fd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
